// ----- rtl/core/sdfp_pkg.sv -----
// Shared types and constants for the series downsampler.
// Depends on nothing; every other file in rtl/core imports it.
package sdfp_pkg;

  localparam int RAW_DEPTH_DEF = 512;
  localparam int OUT_POINTS    = 32;
  localparam int OUT_DIV       = OUT_POINTS - 1;

  typedef struct packed {
    logic [31:0] sample_value;
    logic        sample_absent;
    logic        end_of_series;
  } sample_t;

  typedef struct packed {
    logic [31:0] point_value;
    logic [4:0]  point_index;
    logic [5:0]  point_count;
    logic        last_point;
  } point_t;

endpackage

// ----- rtl/core/sdfp_store.sv -----
// Sample store: one write port, one read port, registered read data.
// Depends on sdfp_pkg for the default depth.
module sdfp_store #(
  parameter int RAW_DEPTH = sdfp_pkg::RAW_DEPTH_DEF,
  localparam int AW = $clog2(RAW_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);
  import sdfp_pkg::*;

  logic [31:0] mem [RAW_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/sdfp_stride.sv -----
// Splits the index span (count - 1) into quotient and remainder by the
// point spacing divisor, over two registered stages. Depends on sdfp_pkg.
module sdfp_stride #(
  parameter int RAW_DEPTH = sdfp_pkg::RAW_DEPTH_DEF,
  localparam int AW = $clog2(RAW_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] span,
  output logic          done,
  output logic [AW-1:0] dq,
  output logic [4:0]    dr
);
  import sdfp_pkg::*;

  // Reciprocal scaled so the estimate is the true quotient or one below it.
  localparam int SHIFT = AW + 4;
  localparam logic [AW-1:0] RECIP = AW'((2 ** SHIFT) / OUT_DIV);

  logic [2*AW-1:0] prod;
  logic [AW-1:0]   span_hold;
  logic            stage1;
  logic [AW-5:0]   q_est;
  logic [AW:0]     q_times;
  logic [AW:0]     r_wide;
  logic [5:0]      r_est;

  always_comb begin
    q_est   = prod[2*AW-1:SHIFT];
    // q * 31 = (q << 5) - q
    q_times = {q_est, 5'b00000} - {5'b00000, q_est};
    r_wide  = {1'b0, span_hold} - q_times;
    r_est   = r_wide[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      done   <= stage1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod      <= span * RECIP;
      span_hold <= span;
    end
    if (stage1) begin
      if (r_est >= 6'(OUT_DIV)) begin
        dq <= AW'(q_est) + 1'b1;
        dr <= 5'(r_est - 6'(OUT_DIV));
      end else begin
        dq <= AW'(q_est);
        dr <= r_est[4:0];
      end
    end
  end

endmodule

// ----- rtl/core/series_downsample_fixed_points_unit.sv -----
// Series downsampler: stores a series, then emits up to 32 evenly spaced points.
// Throughput: one sample transfer per cycle while loading; the end item stalls input.
// Sequence: the end item starts the stride divide, then each point is a store read loaded
//   into the output register; a new read issues only with none in flight and the register free.
// Empty series: the end item leads to the mark state, which emits one marker point once the output is free.
// Reset: clears count, state and valids; store contents stay undefined, no clear pass.
module series_downsample_fixed_points_unit #(
  parameter int RAW_DEPTH = sdfp_pkg::RAW_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  sdfp_pkg::sample_t sample,
  output logic             point_valid,
  input  logic             point_stall,
  output sdfp_pkg::point_t point
);
  import sdfp_pkg::*;

  localparam int AW = $clog2(RAW_DEPTH);
  localparam int CW = $clog2(RAW_DEPTH + 1);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_MARK = 2'd3;

  logic [1:0]    st;
  logic [CW-1:0] kept_count;
  logic [CW-1:0] kept_next;
  logic [CW-1:0] n;
  logic          direct;
  logic [4:0]    j;
  logic [AW-1:0] q;
  logic [4:0]    r;
  logic          inflight;
  logic [4:0]    pend_index;
  logic [5:0]    pend_count;
  logic          pend_last;

  logic          accept;
  logic          wr_en;
  logic          issue;
  logic          last_issue;
  logic          mark_fire;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic          stride_start;
  logic [AW-1:0] span;
  logic          stride_done;
  logic [AW-1:0] dq;
  logic [4:0]    dr;
  logic [5:0]    r_sum;

  // Input side: take samples only while loading.
  assign sample_stall = (st != ST_LOAD);
  assign accept       = sample_valid && !sample_stall;
  assign wr_en        = accept && !sample.sample_absent && (kept_count < CW'(RAW_DEPTH));
  assign kept_next    = wr_en ? kept_count + 1'b1 : kept_count;

  // Start the stride divide on a non-empty end item.
  assign stride_start = accept && sample.end_of_series && (kept_next != '0);
  assign span         = AW'(kept_next - 1'b1);

  // Issue a read only when the output register will be free on delivery.
  assign issue = (st == ST_EMIT) && !inflight && (!point_valid || !point_stall);
  assign mark_fire = (st == ST_MARK) && !inflight && (!point_valid || !point_stall);
  assign rd_addr = direct ? {{(AW-5){1'b0}}, j} : q;
  assign last_issue = direct ? ((6'(j) + 6'd1) == n[5:0]) : (j == 5'(OUT_POINTS - 1));
  assign r_sum = 6'(r) + 6'(dr);

  sdfp_store #(.RAW_DEPTH(RAW_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (kept_count[AW-1:0]),
    .wr_data (sample.sample_value),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sdfp_stride #(.RAW_DEPTH(RAW_DEPTH)) u_stride (
    .clk   (clk),
    .rst   (rst),
    .start (stride_start),
    .span  (span),
    .done  (stride_done),
    .dq    (dq),
    .dr    (dr)
  );

  // Control: count, state, read-in-flight flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_LOAD;
      kept_count <= '0;
      inflight   <= 1'b0;
    end else begin
      inflight <= issue;
      unique case (st)
        ST_LOAD: begin
          if (accept) begin
            if (sample.end_of_series) begin
              kept_count <= '0;
              st         <= (kept_next == '0) ? ST_MARK : ST_DIV;
            end else begin
              kept_count <= kept_next;
            end
          end
        end
        ST_DIV: begin
          if (stride_done) begin
            st <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (issue && last_issue) begin
            st <= ST_LOAD;
          end
        end
        ST_MARK: begin
          if (mark_fire) begin
            st <= ST_LOAD;
          end
        end
        default: st <= ST_LOAD;
      endcase
    end
  end

  // Run bookkeeping: point counter and running index q + r/31.
  always_ff @(posedge clk) begin
    if (stride_start) begin
      n      <= kept_next;
      direct <= (kept_next <= CW'(OUT_POINTS));
    end
    if (st == ST_DIV && stride_done) begin
      j <= '0;
      q <= '0;
      r <= '0;
    end else if (issue) begin
      j          <= j + 1'b1;
      pend_index <= j;
      pend_count <= direct ? n[5:0] : 6'(OUT_POINTS);
      pend_last  <= last_issue;
      // Advance the index by the stride, carrying the remainder.
      if (r_sum >= 6'(OUT_DIV)) begin
        r <= 5'(r_sum - 6'(OUT_DIV));
        q <= q + dq + 1'b1;
      end else begin
        r <= r_sum[4:0];
        q <= q + dq;
      end
    end
  end

  // Output register: load the delivered read or the empty marker, drop on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (inflight || mark_fire) begin
      point_valid <= 1'b1;
    end else if (point_valid && !point_stall) begin
      point_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (inflight) begin
      point.point_value <= rd_data;
      point.point_index <= pend_index;
      point.point_count <= pend_count;
      point.last_point  <= pend_last;
    end else if (mark_fire) begin
      point.point_value <= '0;
      point.point_index <= '0;
      point.point_count <= '0;
      point.last_point  <= 1'b1;
    end
  end

  // A delivered read never lands on a held point.
  assert property (@(posedge clk) disable iff (rst)
    inflight |-> $past(!point_valid || !point_stall))
    else $error("read delivered while output register held");

  assert property (@(posedge clk) disable iff (rst)
    kept_count <= CW'(RAW_DEPTH))
    else $error("kept count beyond store depth");

  assert property (@(posedge clk) disable iff (rst)
    stride_done |-> (st == ST_DIV))
    else $error("stride result outside divide state");

  // Decimated indexes stay inside the kept range.
  assert property (@(posedge clk) disable iff (rst)
    (st == ST_EMIT && !direct) |-> (CW'(q) < n))
    else $error("decimated index out of range");

endmodule
